### design/qrrs_pkg.sv
package qrrs_pkg;

  localparam int MAX_ECC = 30;
  localparam int ECC_MIN = 7;
  localparam int ECC_RST = 10;
  localparam int NUM_GEN = MAX_ECC - ECC_MIN + 1;
  localparam int N_W     = $clog2(MAX_ECC + 1);
  localparam int GIDX_W  = $clog2(NUM_GEN);

  localparam logic [8:0] FIELD_POLY = 9'h11D;

  typedef logic [MAX_ECC:0][7:0]  gen_t;
  typedef gen_t [NUM_GEN-1:0]     gen_tbl_t;

  typedef struct packed {
    logic absorb;
    logic last;
    logic drain;
    logic clear;
  } cell_ctl_t;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x ^= FIELD_POLY;
    end
    return acc;
  endfunction

  // generator for each ecc count, coefficient 0 is the leading (monic) term
  function automatic gen_tbl_t build_gen_tbl();
    gen_tbl_t   tbl;
    gen_t       g;
    logic [7:0] root;
    tbl = '0;
    for (int nn = ECC_MIN; nn <= MAX_ECC; nn++) begin
      g    = '0;
      g[0] = 8'h01;
      root = 8'h01;
      for (int deg = 0; deg < nn; deg++) begin
        g[deg+1] = gf_mul(g[deg], root);
        for (int j = deg; j >= 1; j--) begin
          g[j] = g[j] ^ gf_mul(g[j-1], root);
        end
        root = gf_mul(root, 8'h02);
      end
      tbl[nn-ECC_MIN] = g;
    end
    return tbl;
  endfunction

  localparam gen_tbl_t GEN_TBL = build_gen_tbl();

endpackage

### design/qrrs_cell.sv
module qrrs_cell
  import qrrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] fb_i,
  input  logic [7:0] coef_i,
  input  logic [7:0] rem_nb_i,
  input  logic [7:0] ob_nb_i,
  output logic [7:0] rem_o,
  output logic [7:0] ob_o
);

  logic [7:0] rem_q, rem_d;
  logic [7:0] ob_q, ob_d;
  logic [7:0] mix;

  assign mix = rem_nb_i ^ gf_mul(fb_i, coef_i);

  always_comb begin
    rem_d = rem_q;
    if (ctl_i.clear) begin
      rem_d = '0;
    end else if (ctl_i.absorb) begin
      rem_d = ctl_i.last ? 8'h00 : mix;
    end
  end

  always_comb begin
    ob_d = ob_q;
    if (ctl_i.absorb && ctl_i.last) begin
      ob_d = mix;
    end else if (ctl_i.drain) begin
      ob_d = ob_nb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

  assign rem_o = rem_q;
  assign ob_o  = ob_q;

endmodule

### design/qr_reed_solomon_ecc.sv
// Reed-Solomon ECC encoder for QR blocks, GF(256) with polynomial 0x11D.
// Slave stream: one data codeword per beat in tdata[7:0], tlast on the final
// codeword of a block. Each beat is absorbed by a row of cells, one per remainder
// byte, so a beat can be taken every cycle unless a config write or a waiting last beat holds it.
// Master stream: after the last data beat, the n ECC codewords follow from an
// output shift row, highest degree first, one per cycle while the receiver is ready, tlast on the final
// one. The first ECC beat is valid the cycle after the last data beat.
// The next block streams in while ECC beats drain; only its last beat waits
// until the previous block's final ECC beat goes out (it may be taken in that
// same cycle). If the receiver stalls, output holds and the input keeps
// flowing up to that last beat.
// Config: cfg_data_i sets the ECC count (clamped to 7..30) and clears the
// remainder; accepted only while no ECC beats are pending. A data beat is not
// taken in a cycle where a config write is taken.
// Reset: ECC count 10, remainder cleared, no output pending.
module qr_reed_solomon_ecc
  import qrrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_in_block
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] ecc_byte
  output logic       m_axis_tlast,   // ecc_last
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  logic [N_W-1:0]    n_q, n_d;
  logic [N_W-1:0]    cnt_q, cnt_d;
  gen_t              gen_q, gen_d;
  logic [N_W-1:0]    n_clamp;
  logic [GIDX_W-1:0] gidx;
  logic              s_acc, m_acc, cfg_acc, load;
  cell_ctl_t         ctl;
  logic [7:0]        fb;
  logic [7:0]        rem_q [MAX_ECC];
  logic [7:0]        ob_q  [MAX_ECC];

  assign cfg_ready_o   = (cnt_q == '0);
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = !cfg_acc && ((cnt_q == '0) || !s_axis_tlast ||
                         (m_axis_tready && cnt_q == N_W'(1)));
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == N_W'(1));
  assign m_axis_tdata  = ob_q[0];
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign load          = s_acc && s_axis_tlast;

  always_comb begin
    if (cfg_data_i < N_W'(ECC_MIN)) begin
      n_clamp = N_W'(ECC_MIN);
    end else if (cfg_data_i > N_W'(MAX_ECC)) begin
      n_clamp = N_W'(MAX_ECC);
    end else begin
      n_clamp = N_W'(cfg_data_i);
    end
  end

  assign gidx = GIDX_W'(n_clamp - N_W'(ECC_MIN));

  always_comb begin
    n_d   = n_q;
    gen_d = gen_q;
    if (cfg_acc) begin
      n_d   = n_clamp;
      gen_d = GEN_TBL[gidx];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = n_q;
    end else if (m_acc) begin
      cnt_d = cnt_q - N_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= N_W'(ECC_RST);
      gen_q <= GEN_TBL[ECC_RST-ECC_MIN];
      cnt_q <= '0;
    end else begin
      n_q   <= n_d;
      gen_q <= gen_d;
      cnt_q <= cnt_d;
    end
  end

  assign fb = s_axis_tdata ^ rem_q[0];

  assign ctl.absorb = s_acc;
  assign ctl.last   = s_axis_tlast;
  assign ctl.drain  = m_acc;
  assign ctl.clear  = cfg_acc;

  // coefficients past n are zero, so cells beyond the active length stay zero
  for (genvar i = 0; i < MAX_ECC; i++) begin : g_cell
    logic [7:0] rem_nb, ob_nb;
    if (i == MAX_ECC - 1) begin : g_end
      assign rem_nb = 8'h00;
      assign ob_nb  = 8'h00;
    end else begin : g_mid
      assign rem_nb = rem_q[i+1];
      assign ob_nb  = ob_q[i+1];
    end
    qrrs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .fb_i     (fb),
      .coef_i   (gen_q[i+1]),
      .rem_nb_i (rem_nb),
      .ob_nb_i  (ob_nb),
      .rem_o    (rem_q[i]),
      .ob_o     (ob_q[i])
    );
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q <= n_q)
    else $error("ecc beat count exceeds configured length");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast && cnt_q != '0) |-> (m_acc && m_axis_tlast))
    else $error("block end taken while ecc beats still pending");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (rem_q[0] == 8'h00 && cnt_q == '0))
    else $error("remainder not cleared by config write");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import qrrs_pkg::MAX_ECC;
  import qrrs_pkg::ECC_MIN;
  import qrrs_pkg::ECC_RST;

  localparam int HALF_PERIOD = 6;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  localparam int MAX_PRINTS  = 20;
  localparam logic [5:0] NO_CFG = 6'd32;
  localparam int N_DIR = 22;

  typedef struct packed {
    logic [7:0] ecc_byte;
    logic       ecc_last;
  } ecc_beat_t;

  // cfg == NO_CFG: no write before the beat; zero_cnt != 0: expect that many zero ECC bytes
  typedef struct packed {
    logic [5:0] cfg;
    logic [7:0] data;
    logic       last;
    logic [4:0] zero_cnt;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // last_in_block
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] ecc_byte
  logic       m_axis_tlast;   // ecc_last
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;

  qr_reed_solomon_ecc uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // encoder state mirror
  logic [7:0] gen_coef [0:MAX_ECC];
  logic [7:0] rem_bytes [0:MAX_ECC-1];
  int         ecc_len;
  ecc_beat_t  pending_ecc [$];

  int         errors = 0;
  int         data_beats = 0;
  int         blocks = 0;
  int         ecc_beats = 0;
  int         cfg_writes = 0;
  int         idle_cycles = 0;
  logic [4:0] typed_zeros;
  int         hold_reqs = 0;
  int         holds_done = 0;
  int         burst_left;
  dir_row_t   dir_rows [0:N_DIR-1];

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic logic [7:0] gf256_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic void load_ecc_count(logic [4:0] v);
    int         n;
    logic [7:0] root;
    n = int'(v);
    if (n < ECC_MIN) n = ECC_MIN;
    if (n > MAX_ECC) n = MAX_ECC;
    ecc_len = n;
    for (int j = 0; j <= MAX_ECC; j++) gen_coef[j] = 8'h00;
    gen_coef[0] = 8'h01;
    root = 8'h01;
    for (int deg = 0; deg < n; deg++) begin
      gen_coef[deg+1] = gf256_mul(gen_coef[deg], root);
      for (int j = deg; j >= 1; j--) gen_coef[j] ^= gf256_mul(gen_coef[j-1], root);
      root = gf256_mul(root, 8'h02);
    end
    for (int j = 0; j < MAX_ECC; j++) rem_bytes[j] = 8'h00;
  endfunction

  function automatic void absorb_byte(logic [7:0] d);
    logic [7:0] fb;
    fb = d ^ rem_bytes[0];
    for (int i = 0; i + 1 < ecc_len; i++) begin
      rem_bytes[i] = rem_bytes[i+1] ^ gf256_mul(fb, gen_coef[i+1]);
    end
    rem_bytes[ecc_len-1] = gf256_mul(fb, gen_coef[ecc_len]);
  endfunction

  // output check runs before the input side so a same-cycle last beat cannot be popped
  always @(posedge clk_i) begin
    ecc_beat_t want;
    if (!rst_ni) begin
      load_ecc_count(5'(ECC_RST));
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        ecc_beats++;
        if (pending_ecc.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: unexpected ECC beat, actual byte %02h last %0b",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_ecc.pop_front();
          if (m_axis_tdata !== want.ecc_byte || m_axis_tlast !== want.ecc_last) begin
            errors++;
            if (errors <= MAX_PRINTS)
              $display("%0t: ECC mismatch, expected byte %02h last %0b, actual byte %02h last %0b",
                       $time, want.ecc_byte, want.ecc_last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        load_ecc_count(cfg_data_i);
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata);
        data_beats++;
        if (s_axis_tlast) begin
          blocks++;
          if (typed_zeros != 0) begin
            for (int i = 0; i < typed_zeros; i++) begin
              want.ecc_byte = 8'h00;
              want.ecc_last = (i == typed_zeros - 1);
              pending_ecc.insert(pending_ecc.size(), want);
            end
          end else begin
            for (int i = 0; i < ecc_len; i++) begin
              want.ecc_byte = rem_bytes[i];
              want.ecc_last = (i == ecc_len - 1);
              pending_ecc.insert(pending_ecc.size(), want);
            end
          end
          for (int j = 0; j < MAX_ECC; j++) rem_bytes[j] = 8'h00;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver backpressure
  initial begin
    int rx_mode;
    int mode_left;
    rx_mode       = 0;
    mode_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_reqs) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic [7:0] d, logic last, logic [4:0] zeros);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    typed_zeros = zeros;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_ecc.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_ecc_count(logic [4:0] v);
    wait_drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int         sent;
    int         len;
    logic [4:0] cfgv;
    bit         leftover;
    leftover      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 5'd0;
    typed_zeros   = 5'd0;
    burst_left    = 0;

    dir_rows = '{
      '{NO_CFG, 8'h00, 1'b1, 5'd10},   // zero block right after reset, count 10
      '{NO_CFG, 8'hFF, 1'b1, 5'd0},
      '{NO_CFG, 8'h01, 1'b0, 5'd0},
      '{NO_CFG, 8'h80, 1'b0, 5'd0},
      '{NO_CFG, 8'h55, 1'b1, 5'd0},
      '{6'd0,   8'h00, 1'b1, 5'd7},    // count 0 clamps to 7
      '{NO_CFG, 8'hAA, 1'b0, 5'd0},
      '{NO_CFG, 8'hFF, 1'b1, 5'd0},
      '{6'd31,  8'h00, 1'b1, 5'd30},   // count 31 clamps to 30
      '{NO_CFG, 8'hFF, 1'b0, 5'd0},
      '{NO_CFG, 8'hFF, 1'b0, 5'd0},
      '{NO_CFG, 8'hFF, 1'b1, 5'd0},
      '{6'd6,   8'h3C, 1'b1, 5'd0},
      '{6'd7,   8'hC3, 1'b0, 5'd0},
      '{NO_CFG, 8'h00, 1'b0, 5'd0},
      '{NO_CFG, 8'h01, 1'b1, 5'd0},
      '{6'd30,  8'h7E, 1'b1, 5'd0},
      '{NO_CFG, 8'h11, 1'b0, 5'd0},
      '{NO_CFG, 8'h22, 1'b0, 5'd0},
      '{6'd16,  8'h33, 1'b1, 5'd0},    // rewrite drops the partial block
      '{NO_CFG, 8'h00, 1'b0, 5'd0},
      '{NO_CFG, 8'h00, 1'b1, 5'd16}
    };

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].cfg != NO_CFG) write_ecc_count(dir_rows[r].cfg[4:0]);
      send_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].zero_cnt);
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cfgv = 5'd7;
        1: cfgv = 5'd30;
        2: cfgv = 5'd0;
        3: cfgv = 5'd31;
        default: cfgv = 5'($urandom_range(0, 31));
      endcase
      write_ecc_count(cfgv);
      sent = 0;
      // in the hold phase keep offering blocks until the long stall is over
      while (sent < 20 || (phase == 2 && holds_done == 0)) begin
        if (phase == 2 && sent > 0 && hold_reqs == 0) hold_reqs = 1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) send_beat(rand_byte(), k == len - 1, 5'd0);
        sent += len;
      end
      // broken block: partial data, then the next count write discards it
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) send_beat(rand_byte(), 1'b0, 5'd0);
      end
    end

    wait_drain();
    repeat (40) @(negedge clk_i);
    if (pending_ecc.size() != 0) begin
      leftover = 1'b1;
      $display("%0t: %0d ECC beats still expected", $time, pending_ecc.size());
    end
    $display("Encoded %0d blocks from %0d data beats, %0d ECC beats compared, %0d count writes",
             blocks, data_beats, ecc_beats, cfg_writes);
    $display("Counts spanned clamped low and high values, with partial blocks and stalls");
    if (errors == 0 && !leftover) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
